>>> src/matrix_rotate_clockwise_assert.svh
// Assertion macros shared by the matrix rotation RTL.
// No dependencies; included by the files that check their own logic.
`ifndef MATRIX_ROTATE_CLOCKWISE_ASSERT_SVH
`define MATRIX_ROTATE_CLOCKWISE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrc: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define MRC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrc: next-cycle check failed");

`endif

>>> src/mrc_pkg.sv
// Package for the matrix rotation block: sizes, codes, control types, clamp helper.
// No dependencies.
`default_nettype none

package mrc_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int ROW_W       = $clog2(MAX_COLS);   // output row index, < cols
  localparam int COL_W       = $clog2(MAX_ROWS);   // output column index, < rows
  localparam int DIM_W       = 7;                  // width of the size registers
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  typedef enum logic [0:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;   // write element, advance load count
    logic pull;   // latch read address and flags, advance output position
    logic err;    // form an error result
    logic read;   // read the store into the result register
  } cmd_t;

  typedef struct packed {
    logic loaded;
    logic full;
  } status_t;

  // Zero counts as one, anything above the maximum as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/mrc_ifs.sv
// Valid/ready channel interfaces for the matrix rotation block.
// Depends on mrc_pkg for the data width.
`default_nettype none

interface mrc_in_if import mrc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [DATA_WIDTH-1:0] element;

  modport source (output valid, func, element, input ready);
  modport sink   (input valid, func, element, output ready);
endinterface

interface mrc_out_if import mrc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] rotated_element;
  logic                         row_end;
  logic                         last;
  logic                         error;

  modport source (output valid, rotated_element, row_end, last, error, input ready);
  modport sink   (input valid, rotated_element, row_end, last, error, output ready);
endinterface

`default_nettype wire

>>> src/mrc_ctrl.sv
// Controller of the matrix rotation block: sequences loads, pulls and results.
// Depends on mrc_pkg and the assertion macro header.
`default_nettype none
`include "matrix_rotate_clockwise_assert.svh"

module mrc_ctrl import mrc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_func,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;
  state_t item_state;
  logic   accept;
  logic   load_ok;
  logic   pull_ok;

  assign accept  = in_valid && in_ready;
  assign load_ok = !in_func && !status.loaded && !status.full;
  assign pull_ok = in_func && status.loaded;
  assign item_state = pull_ok ? ST_READ : (load_ok ? ST_IDLE : ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = item_state;
      end
      ST_READ: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_next = accept ? item_state : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.load = accept && load_ok;
    cmd.pull = accept && pull_ok;
    cmd.err  = accept && !load_ok && !pull_ok;
  end

  `MRC_ASSERT_NXT(a_read_then_out, clk, rst, state == ST_READ, state == ST_OUT)
  `MRC_ASSERT_NXT(a_out_holds, clk, rst, state == ST_OUT && !out_ready, state == ST_OUT)
  `MRC_ASSERT_IMP(a_load_fits, clk, rst, cmd.load, !status.full && !status.loaded)
  `MRC_ASSERT_IMP(a_pull_loaded, clk, rst, cmd.pull, status.loaded)

endmodule

`default_nettype wire

>>> src/mrc_datapath.sv
// Datapath of the matrix rotation block: element store, counters, result register.
// Depends on mrc_pkg and the assertion macro header.
`default_nettype none
`include "matrix_rotate_clockwise_assert.svh"

module mrc_datapath import mrc_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cmd_t                         cmd,
  input  wire logic                         restart,
  input  wire logic        [DIM_W-1:0]      rows,
  input  wire logic        [DIM_W-1:0]      cols,
  input  wire logic signed [DATA_WIDTH-1:0] element,
  output status_t                           status,
  output logic signed [DATA_WIDTH-1:0]      rotated_element,
  output logic                              row_end,
  output logic                              last,
  output logic                              error
);

  logic [DATA_WIDTH-1:0]  store_mem [STORE_DEPTH];

  logic [CNT_W-1:0]       load_count;
  logic [ROW_W-1:0]       out_row;
  logic [COL_W-1:0]       out_col;
  logic                   loaded;
  logic [ADDR_W-1:0]      rd_addr;

  logic [CNT_W-1:0]       total;
  logic [CNT_W-1:0]       load_inc;
  logic [DIM_W-1:0]       rows_m1;
  logic [DIM_W-1:0]       cols_m1;
  logic [COL_W-1:0]       src_row;
  logic [COL_W+DIM_W-1:0] row_base;
  logic [COL_W+DIM_W-1:0] addr_sum;
  logic                   rend;
  logic                   fin;
  logic                   pos_ok;

  assign total    = CNT_W'(rows) * CNT_W'(cols);
  assign load_inc = load_count + CNT_W'(1);
  assign rows_m1  = rows - DIM_W'(1);
  assign cols_m1  = cols - DIM_W'(1);
  assign src_row  = rows_m1[COL_W-1:0] - out_col;
  assign row_base = src_row * cols;
  assign addr_sum = row_base + (COL_W+DIM_W)'(out_row);
  assign rend     = DIM_W'(out_col) == rows_m1;
  assign fin      = rend && (DIM_W'(out_row) == cols_m1);
  assign pos_ok   = (DIM_W'(out_col) < rows) && (DIM_W'(out_row) < cols);

  assign status.loaded = loaded;
  assign status.full   = load_count >= total;

  // Counters: load position and output position
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      load_count <= '0;
      out_row    <= '0;
      out_col    <= '0;
      loaded     <= 1'b0;
    end else if (cmd.load) begin
      load_count <= load_inc;
      if (load_inc >= total) loaded <= 1'b1;
    end else if (cmd.pull) begin
      if (fin) begin
        load_count <= '0;
        out_row    <= '0;
        out_col    <= '0;
        loaded     <= 1'b0;
      end else if (rend) begin
        out_col <= '0;
        out_row <= out_row + ROW_W'(1);
      end else begin
        out_col <= out_col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) store_mem[load_count[ADDR_W-1:0]] <= element;
  end

  // Result register: flags at accept, data from the store in the cycle after
  always_ff @(posedge clk) begin
    if (cmd.pull) begin
      rd_addr <= ADDR_W'(addr_sum);
      row_end <= rend;
      last    <= fin;
      error   <= 1'b0;
    end else if (cmd.err) begin
      rotated_element <= '0;
      row_end         <= 1'b0;
      last            <= 1'b0;
      error           <= 1'b1;
    end
    if (cmd.read) rotated_element <= store_mem[rd_addr];
  end

  `MRC_ASSERT_IMP(a_loaded_full, clk, rst, loaded, load_count == total)
  `MRC_ASSERT_IMP(a_full_loaded, clk, rst, status.full, loaded)
  `MRC_ASSERT_IMP(a_pull_in_range, clk, rst, cmd.pull, pos_ok)

endmodule

`default_nettype wire

>>> src/matrix_rotate_clockwise.sv
// Matrix rotation by 90 degrees clockwise:
//   item   (sink)  : func=0 loads the next element of a rows x cols matrix in row-major
//                    order; func=1 pulls the next element of the rotated matrix.
//   result (source): rotated_element with row_end / last marks, or error=1 for a load
//                    past the end of the matrix or a pull before the matrix is full.
//   APB port       : row_count at 0x0, col_count at 0x4 (7 bits, 0 counts as 1,
//                    above 64 clamps to 64). Writing either abandons the matrix.
// Loads produce no result and go at one beat per cycle. A pull registers its read
// address and flags at acceptance, then does the registered read of the single-port
// element store; an error result is valid in the cycle after acceptance. With the
// receiver ready, pulls do not overlap: no item is taken while a pull reads the store,
// and the next item is taken in the same cycle the waiting result is taken.
// While the receiver stalls, the result holds and no new item is taken.
// Reset clears the counters and sets both sizes to 1; the store keeps old data and
// needs no clearing pass, since a pull only reads entries of the current matrix.
// Depends on mrc_pkg, mrc_ifs, mrc_ctrl and mrc_datapath.
`default_nettype none

module matrix_rotate_clockwise import mrc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  mrc_in_if.sink                  item,
  mrc_out_if.source               result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic [DIM_W-1:0] row_count;
  logic [DIM_W-1:0] col_count;
  logic [DIM_W-1:0] rows;
  logic [DIM_W-1:0] cols;
  reg_idx_t         reg_idx;
  logic             cfg_wr;
  cmd_t             cmd;
  status_t          status;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Size registers; any write restarts the matrix in the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_W'(1);
      col_count <= DIM_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ROW_COUNT: row_count <= pwdata[DIM_W-1:0];
        REG_COL_COUNT: col_count <= pwdata[DIM_W-1:0];
        default: begin
          row_count <= row_count;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW_COUNT: prdata = PDATA_W'(row_count);
      REG_COL_COUNT: prdata = PDATA_W'(col_count);
      default:       prdata = '0;
    endcase
  end

  // Clamp once here so the datapath only sees legal sizes
  assign rows = clamp_dim(row_count, DIM_W'(MAX_ROWS));
  assign cols = clamp_dim(col_count, DIM_W'(MAX_COLS));

  mrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_func   (item.func),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mrc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .restart         (cfg_wr),
    .rows            (rows),
    .cols            (cols),
    .element         (item.element),
    .status          (status),
    .rotated_element (result.rotated_element),
    .row_end         (result.row_end),
    .last            (result.last),
    .error           (result.error)
  );

endmodule

`default_nettype wire
